// ===== sv/deq_pkg.sv =====
// Shared types and codes for the double-ended queue.
// No dependencies; imported by deq_store, double_ended_queue and the bench.
package deq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int WORD_W    = 32;

  // request codes
  localparam logic [1:0] RQ_REAR_INS  = 2'd0;
  localparam logic [1:0] RQ_FRONT_REM = 2'd1;
  localparam logic [1:0] RQ_FRONT_INS = 2'd2;
  localparam logic [1:0] RQ_REAR_REM  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic        [1:0]        req_type;
    logic signed [WORD_W-1:0] data_in;
  } deq_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] data_out;
    logic        [1:0]        status;
    logic                     now_empty;
  } deq_out_t;

endpackage

// ===== sv/deq_store.sv =====
// Single-port word store for the queue, registered read.
// Depends on deq_pkg.
module deq_store
  import deq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [AW-1:0]     addr,
  input  logic [WORD_W-1:0] wdata,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    // read data holds while no read is issued, so a stalled result keeps it
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/double_ended_queue.sv =====
// Double-ended queue top level: index/flag control around a word store.
// Depends on deq_pkg and deq_store.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one request word:
//   rear insert, front remove, front insert or rear remove. Every request
//   yields exactly one result word on out_valid/out_ready/out_data with the
//   removed word (zero otherwise), a status (ok, full at that end, empty)
//   and the empty flag after the request.
//   out_valid rises in the cycle after acceptance. Throughput is one
//   request per cycle while out_ready is high: indices and flag live in
//   registers and update at acceptance, and the store takes one read or
//   one write per request on its single port, so a removal right after an
//   insert of the same slot reads the new word without forwarding.
//   The queue is a linear array: inserts past slot 0 or slot DEPTH-1 are
//   refused as full even when the other end has room.
//   Reset empties the queue (indices to zero); store contents are not
//   cleared and are only read once written.
//   When out_ready is low the result holds and in_ready drops; a new
//   request is taken in the same cycle the pending result is taken.
module double_ended_queue
  import deq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  deq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output deq_out_t out_data
);

  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic          empty_r, empty_nxt;
  logic          out_valid_r;
  logic [1:0]    status_r, status_nxt;
  logic          take_rd_r, take_rd_nxt;

  logic          accept;
  logic          wr_req, rd_req;
  logic [AW-1:0] addr;
  logic [WORD_W-1:0] rdata;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    empty_nxt   = empty_r;
    status_nxt  = ST_OK;
    take_rd_nxt = 1'b0;
    wr_req      = 1'b0;
    rd_req      = 1'b0;
    addr        = head_r;
    unique case (in_data.req_type)
      RQ_REAR_INS: begin
        if (empty_r) begin
          head_nxt  = '0;
          tail_nxt  = '0;
          addr      = '0;
          wr_req    = 1'b1;
          empty_nxt = 1'b0;
        end else if (tail_r == LAST_IDX) begin
          status_nxt = ST_FULL;
        end else begin
          tail_nxt = tail_r + 1'b1;
          addr     = tail_r + 1'b1;
          wr_req   = 1'b1;
        end
      end
      RQ_FRONT_INS: begin
        if (empty_r) begin
          head_nxt  = LAST_IDX;
          tail_nxt  = LAST_IDX;
          addr      = LAST_IDX;
          wr_req    = 1'b1;
          empty_nxt = 1'b0;
        end else if (head_r == '0) begin
          status_nxt = ST_FULL;
        end else begin
          head_nxt = head_r - 1'b1;
          addr     = head_r - 1'b1;
          wr_req   = 1'b1;
        end
      end
      RQ_FRONT_REM, RQ_REAR_REM: begin
        if (empty_r) begin
          status_nxt = ST_EMPTY;
        end else begin
          rd_req      = 1'b1;
          take_rd_nxt = 1'b1;
          addr        = (in_data.req_type == RQ_FRONT_REM) ? head_r : tail_r;
          if (head_r == tail_r) begin
            empty_nxt = 1'b1;
            head_nxt  = '0;
            tail_nxt  = '0;
          end else if (in_data.req_type == RQ_FRONT_REM) begin
            head_nxt = head_r + 1'b1;
          end else begin
            tail_nxt = tail_r - 1'b1;
          end
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  deq_store #(.DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (accept && wr_req),
    .re    (accept && rd_req),
    .addr  (addr),
    .wdata (in_data.data_in),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      empty_r     <= 1'b1;
      out_valid_r <= 1'b0;
      status_r    <= ST_OK;
      take_rd_r   <= 1'b0;
    end else begin
      if (accept) begin
        head_r    <= head_nxt;
        tail_r    <= tail_nxt;
        empty_r   <= empty_nxt;
        status_r  <= status_nxt;
        take_rd_r <= take_rd_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_data.data_out  = take_rd_r ? rdata : '0;
  assign out_data.status    = status_r;
  assign out_data.now_empty = empty_r;

  // occupied slots stay contiguous from head to tail
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    !empty_r |-> (head_r <= tail_r))
    else $error("head index passed tail index");

  a_empty_idx: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r |-> (head_r == '0 && tail_r == '0))
    else $error("empty queue with nonzero indices");

  a_rem_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && empty_r && (in_data.req_type == RQ_FRONT_REM ||
     in_data.req_type == RQ_REAR_REM)) |=> (status_r == ST_EMPTY && !take_rd_r))
    else $error("removal from empty queue not reported");

  a_no_access_on_err: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && status_nxt != ST_OK) |-> (!wr_req && !rd_req))
    else $error("store accessed on refused request");

  a_count_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !empty_r && in_data.req_type == RQ_REAR_INS && tail_r != LAST_IDX)
    |=> (tail_r == $past(tail_r) + 1'b1 && head_r == $past(head_r)))
    else $error("rear insert moved indices wrongly");

endmodule

// ===== sim/double_ended_queue_test.sv =====
// Self-checking bench for double_ended_queue: random and directed requests,
// scoreboard with its own deque predictor. Depends on deq_pkg and the block RTL.
module double_ended_queue_test
  import deq_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = DEPTH_DEF;
  localparam int RAND_PER_PHASE = 646;

  class deq_scoreboard;
    logic [WORD_W-1:0] slots [DEPTH];
    int unsigned head_idx;
    int unsigned tail_idx;
    bit is_empty;
    deq_out_t pending_results[$];
    int unsigned errors;

    function new();
      head_idx = 0;
      tail_idx = 0;
      is_empty = 1'b1;
      errors = 0;
    endfunction

    // apply one accepted request to the shadow deque, queue the result it yields
    function void note_request(deq_in_t w);
      deq_out_t r;
      r = '0;
      r.status = ST_OK;
      case (w.req_type)
        RQ_REAR_INS: begin
          if (is_empty) begin
            head_idx = 0;
            tail_idx = 0;
            slots[0] = w.data_in;
            is_empty = 1'b0;
          end else if (tail_idx == DEPTH - 1) begin
            r.status = ST_FULL;
          end else begin
            tail_idx++;
            slots[tail_idx] = w.data_in;
          end
        end
        RQ_FRONT_INS: begin
          if (is_empty) begin
            head_idx = DEPTH - 1;
            tail_idx = DEPTH - 1;
            slots[DEPTH-1] = w.data_in;
            is_empty = 1'b0;
          end else if (head_idx == 0) begin
            r.status = ST_FULL;
          end else begin
            head_idx--;
            slots[head_idx] = w.data_in;
          end
        end
        RQ_FRONT_REM: begin
          if (is_empty) begin
            r.status = ST_EMPTY;
          end else begin
            r.data_out = slots[head_idx];
            if (head_idx == tail_idx) begin
              is_empty = 1'b1;
              head_idx = 0;
              tail_idx = 0;
            end else begin
              head_idx++;
            end
          end
        end
        default: begin
          if (is_empty) begin
            r.status = ST_EMPTY;
          end else begin
            r.data_out = slots[tail_idx];
            if (head_idx == tail_idx) begin
              is_empty = 1'b1;
              head_idx = 0;
              tail_idx = 0;
            end else begin
              tail_idx--;
            end
          end
        end
      endcase
      r.now_empty = is_empty;
      pending_results.push_back(r);
    endfunction

    function void check_result(deq_out_t got);
      deq_out_t exp_w;
      if (pending_results.size() == 0) begin
        $error("result word with no request outstanding: %p", got);
        errors++;
        return;
      end
      exp_w = pending_results.pop_front();
      if (got.data_out !== exp_w.data_out) begin
        $error("data_out: expected %0h, got %0h", exp_w.data_out, got.data_out);
        errors++;
      end
      if (got.status !== exp_w.status) begin
        $error("status: expected %0d, got %0d", exp_w.status, got.status);
        errors++;
      end
      if (got.now_empty !== exp_w.now_empty) begin
        $error("now_empty: expected %0b, got %0b", exp_w.now_empty, got.now_empty);
        errors++;
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  deq_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  deq_out_t out_data;

  deq_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned recv_hold = 0;

  double_ended_queue #(.DEPTH(DEPTH)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  // receiver: random stalls, plus a long hold-off when requested
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (recv_hold != 0) begin
        out_ready <= 1'b0;
        recv_hold--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic deq_in_t request(logic [1:0] req, logic [WORD_W-1:0] word);
    deq_in_t w;
    w.req_type = req;
    w.data_in = word;
    return w;
  endfunction

  // called and returns at a falling edge
  task automatic send_word(input deq_in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [WORD_W-1:0] pick_data();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      default: return $urandom;
    endcase
  endfunction

  // insert_pct sets how hard the mix drives toward the ends of the array
  task automatic send_random(int unsigned count);
    int unsigned insert_pct;
    logic [1:0] req;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(3))
          0: insert_pct = 85;
          1: insert_pct = 50;
          2: insert_pct = 20;
          default: insert_pct = 65;
        endcase
      end
      if ($urandom_range(99) < insert_pct)
        req = $urandom_range(1) ? RQ_REAR_INS : RQ_FRONT_INS;
      else
        req = $urandom_range(1) ? RQ_REAR_REM : RQ_FRONT_REM;
      send_word(request(req, pick_data()));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // removals while empty, then both ends of the linear array
    send_word(request(RQ_FRONT_REM, 32'h1234_5678));
    send_word(request(RQ_REAR_REM, 32'hFFFF_FFFF));
    send_word(request(RQ_REAR_INS, 32'h7FFF_FFFF));
    send_word(request(RQ_FRONT_INS, 32'h5555_5555));   // head at slot 0: full
    send_word(request(RQ_REAR_INS, 32'h8000_0000));
    send_word(request(RQ_REAR_REM, 32'h0));
    send_word(request(RQ_FRONT_REM, 32'h0));           // last word out
    send_word(request(RQ_FRONT_INS, 32'hFFFF_FFFF));   // empty: starts at top slot
    send_word(request(RQ_REAR_INS, 32'hAAAA_AAAA));    // tail at top slot: full
    send_word(request(RQ_FRONT_INS, 32'h0));
    send_word(request(RQ_FRONT_REM, 32'h0));
    send_word(request(RQ_REAR_REM, 32'h0));
    send_word(request(RQ_REAR_REM, 32'h0));
    send_word(request(RQ_FRONT_INS, 32'h0000_0001));
    send_word(request(RQ_REAR_REM, 32'h0));

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin send_idle_pct = 28; recv_idle_pct = 54; end
        1: begin send_idle_pct = 54; recv_idle_pct = 28; end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          recv_hold = 300;   // sender keeps offering, block backs up
        end
      endcase
      send_random(RAND_PER_PHASE);
      wait_drained();
    end

    recv_idle_pct = 0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #200000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
